### src/dpr_pkg.sv
// shared types, constants and helpers of the debug packet receiver
package dpr_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned BURST_N     = 4;
  localparam int unsigned BCNT_W      = 3;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ACK   = 8'h2b;
  localparam logic [7:0] CH_NAK   = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              out_kind;
    logic [7:0]         data_byte;
    logic [IDX_W-1:0]   payload_index;
    status_e            packet_status;
    logic [CNT_W-1:0]   packet_length;
    logic               has_sequence;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [BCNT_W-1:0]         count;
    result_t [BURST_N-1:0]     entry;
  } burst_t;

  // bit 4 set for a byte that is no hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      v = {1'b0, 4'(c[3:0] + 4'd9)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

### src/dpr_if.sv
// byte and result channel interfaces of the debug packet receiver
interface dpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dpr_tx_if;
  logic                       valid;
  logic                       ready;
  dpr_pkg::kind_e             out_kind;
  logic [7:0]                 data_byte;
  logic [dpr_pkg::IDX_W-1:0]  payload_index;
  dpr_pkg::status_e           packet_status;
  logic [dpr_pkg::CNT_W-1:0]  packet_length;
  logic                       has_sequence;
  logic                       last;

  modport source (output valid, output out_kind, output data_byte, output payload_index,
                  output packet_status, output packet_length, output has_sequence,
                  output last, input ready);
  modport sink (input valid, input out_kind, input data_byte, input payload_index,
                input packet_status, input packet_length, input has_sequence,
                input last, output ready);
endinterface

### src/dpr_parser.sv
// framing state machine and checksum, builds the results of one byte
module dpr_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  output dpr_pkg::burst_t burst_o
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_HI   = 2'd2,
    PH_LO   = 2'd3
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [7:0]                sum_q, sum_d;
  logic [dpr_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]                hi_q, hi_d;
  logic                      inv_q, inv_d;
  logic [7:0]                head_q [3];
  logic                      head_we;
  logic [4:0]                hex;
  logic                      seq_now;
  logic                      seq_new;
  logic                      bad;

  function automatic dpr_pkg::result_t mk(dpr_pkg::kind_e k, logic [7:0] d,
                                          logic [dpr_pkg::IDX_W-1:0] i,
                                          dpr_pkg::status_e s,
                                          logic [dpr_pkg::CNT_W-1:0] l,
                                          logic q, logic lst);
    dpr_pkg::result_t r;
    r.out_kind      = k;
    r.data_byte     = d;
    r.payload_index = i;
    r.packet_status = s;
    r.packet_length = l;
    r.has_sequence  = q;
    r.last          = lst;
    return r;
  endfunction

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    inv_d   = inv_q;
    head_we = 1'b0;
    hex     = dpr_pkg::hex_value(rx_byte_i);
    seq_now = (cnt_q >= dpr_pkg::CNT_W'(3)) && (head_q[2] == dpr_pkg::CH_COLON);
    seq_new = 1'b0;
    bad     = inv_q || hex[4] || ({hi_q, hex[3:0]} != sum_q);
    burst_o = '0;
    case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == dpr_pkg::CH_START) begin
          sum_d   = '0;
          cnt_d   = '0;
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        if (rx_byte_i == dpr_pkg::CH_START) begin
          sum_d = '0;
          cnt_d = '0;
        end else if (rx_byte_i == dpr_pkg::CH_END) begin
          phase_d = PH_HI;
        end else begin
          sum_d   = sum_q + rx_byte_i;
          cnt_d   = cnt_q + dpr_pkg::CNT_W'(1);
          head_we = (cnt_q < dpr_pkg::CNT_W'(3));
          // third byte may be the one arriving now
          seq_new = (cnt_d >= dpr_pkg::CNT_W'(3)) &&
                    (((cnt_q == dpr_pkg::CNT_W'(2)) ? rx_byte_i : head_q[2])
                     == dpr_pkg::CH_COLON);
          if (cnt_d == dpr_pkg::CNT_W'(dpr_pkg::MAX_PAYLOAD)) begin
            burst_o.count    = dpr_pkg::BCNT_W'(2);
            burst_o.entry[0] = mk(dpr_pkg::KIND_PAYLOAD, rx_byte_i,
                                  cnt_q[dpr_pkg::IDX_W-1:0], dpr_pkg::ST_GOOD,
                                  '0, 1'b0, 1'b0);
            burst_o.entry[1] = mk(dpr_pkg::KIND_STATUS, 8'h00, '0,
                                  dpr_pkg::ST_OVERFLOW, cnt_d, seq_new, 1'b1);
            phase_d          = PH_HUNT;
          end else begin
            burst_o.count    = dpr_pkg::BCNT_W'(1);
            burst_o.entry[0] = mk(dpr_pkg::KIND_PAYLOAD, rx_byte_i,
                                  cnt_q[dpr_pkg::IDX_W-1:0], dpr_pkg::ST_GOOD,
                                  '0, 1'b0, 1'b1);
          end
        end
      end
      PH_HI: begin
        inv_d   = hex[4];
        hi_d    = hex[3:0];
        phase_d = PH_LO;
      end
      default: begin
        if (bad) begin
          burst_o.count    = dpr_pkg::BCNT_W'(2);
          burst_o.entry[0] = mk(dpr_pkg::KIND_REPLY, dpr_pkg::CH_NAK, '0,
                                dpr_pkg::ST_GOOD, '0, 1'b0, 1'b0);
          burst_o.entry[1] = mk(dpr_pkg::KIND_STATUS, 8'h00, '0,
                                dpr_pkg::ST_BAD_SUM, cnt_q, seq_now, 1'b1);
        end else if (seq_now) begin
          burst_o.count    = dpr_pkg::BCNT_W'(4);
          burst_o.entry[0] = mk(dpr_pkg::KIND_REPLY, dpr_pkg::CH_ACK, '0,
                                dpr_pkg::ST_GOOD, '0, 1'b0, 1'b0);
          burst_o.entry[1] = mk(dpr_pkg::KIND_REPLY, head_q[0], '0,
                                dpr_pkg::ST_GOOD, '0, 1'b0, 1'b0);
          burst_o.entry[2] = mk(dpr_pkg::KIND_REPLY, head_q[1], '0,
                                dpr_pkg::ST_GOOD, '0, 1'b0, 1'b0);
          burst_o.entry[3] = mk(dpr_pkg::KIND_STATUS, 8'h00, '0,
                                dpr_pkg::ST_GOOD, cnt_q, 1'b1, 1'b1);
        end else begin
          burst_o.count    = dpr_pkg::BCNT_W'(2);
          burst_o.entry[0] = mk(dpr_pkg::KIND_REPLY, dpr_pkg::CH_ACK, '0,
                                dpr_pkg::ST_GOOD, '0, 1'b0, 1'b0);
          burst_o.entry[1] = mk(dpr_pkg::KIND_STATUS, 8'h00, '0,
                                dpr_pkg::ST_GOOD, cnt_q, 1'b0, 1'b1);
        end
        inv_d   = 1'b0;
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      sum_q   <= '0;
      cnt_q   <= '0;
      hi_q    <= '0;
      inv_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      hi_q    <= hi_d;
      inv_q   <= inv_d;
    end
  end

  // first three payload bytes of the packet
  always_ff @(posedge clk_i) begin
    if (accept_i && head_we) begin
      head_q[cnt_q[1:0]] <= rx_byte_i;
    end
  end

endmodule

### src/dpr_burst.sv
// result buffer that hands out the results of one byte, one per cycle while out_ready_i is high
module dpr_burst (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  dpr_pkg::burst_t  burst_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output dpr_pkg::result_t out_res_o,
  output logic             in_ready_o
);

  logic [dpr_pkg::BCNT_W-1:0]       cnt_q, cnt_d;
  dpr_pkg::result_t [dpr_pkg::BURST_N-1:0] ent_q, ent_d;
  logic                             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == dpr_pkg::BCNT_W'(1)) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    ent_d = ent_q;
    if (load_i) begin
      cnt_d = burst_i.count;
      ent_d = burst_i.entry;
    end else if (pop) begin
      cnt_d = cnt_q - dpr_pkg::BCNT_W'(1);
      for (int i = 0; i < dpr_pkg::BURST_N - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

### src/debug_packet_receiver.sv
// top level of the debug packet receiver
//
// rx_i takes one byte from the host link per transfer. tx_o gives results:
// payload bytes as they arrive, reply bytes to send back ('+', '-', the
// echoed sequence id) and one status result at the end of every packet.
// last marks the final result caused by one received byte.
// A byte is decoded in the cycle it is accepted and its results appear on
// tx_o from the next cycle on, one per cycle, up to four per byte. While
// tx_o is ready, a byte with one result can follow in every cycle; a byte
// with more results holds rx_i until the result buffer, which drains one
// per cycle, is down to its last result. Bytes that cause no result
// (framing characters, first checksum digit) leave rx_i ready.
// Reset leaves the block hunting for a start marker with an empty buffer.
// When tx_o stalls, the buffered results wait and rx_i.ready drops until
// the last one of them is taken.
module debug_packet_receiver (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpr_rx_if.sink    rx_i,
  dpr_tx_if.source  tx_o
);

  dpr_pkg::burst_t  burst;
  dpr_pkg::result_t res;
  logic             in_ready;
  logic             out_valid;
  logic             accept;

  assign accept = rx_i.valid && in_ready;

  dpr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .burst_o   (burst)
  );

  dpr_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .burst_i     (burst),
    .out_ready_i (tx_o.ready),
    .out_valid_o (out_valid),
    .out_res_o   (res),
    .in_ready_o  (in_ready)
  );

  assign rx_i.ready         = in_ready;
  assign tx_o.valid         = out_valid;
  assign tx_o.out_kind      = res.out_kind;
  assign tx_o.data_byte     = res.data_byte;
  assign tx_o.payload_index = res.payload_index;
  assign tx_o.packet_status = res.packet_status;
  assign tx_o.packet_length = res.packet_length;
  assign tx_o.has_sequence  = res.has_sequence;
  assign tx_o.last          = res.last;

  a_stall_blocks_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !tx_o.ready) |-> !in_ready)
    else $error("byte accepted while results are stalled");

  a_burst_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (burst.count != '0)) |=> out_valid)
    else $error("results of an accepted byte missing");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && tx_o.ready && !res.last) |=> out_valid)
    else $error("result burst ended without last");

endmodule
